// ----- rtl/utf8_to_byte_level_bytes_defines.svh -----
// Assertion macros for the byte-level decoder checker.
// Each macro expects a clock named aclk and an active-low reset named aresetn in scope.
`ifndef UTF8_TO_BYTE_LEVEL_BYTES_DEFINES_SVH
`define UTF8_TO_BYTE_LEVEL_BYTES_DEFINES_SVH

// Same-cycle implication, ignored while in reset.
`define U2B_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("u2b check failed");

// Next-cycle implication, ignored while in reset.
`define U2B_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("u2b check failed");

// Next-cycle implication that also holds across reset.
`define U2B_ASSERT_ALWAYS(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) (ante) |=> (cons)) \
        else $error("u2b check failed");

`endif

// ----- rtl/u2b_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u2b_pkg
// Types, constants and the inverse byte-level map for the UTF-8 byte decoder.
// ----------------------------------------------------------------------------
package u2b_pkg;

    localparam logic [7:0] QMARK      = 8'd63;
    localparam logic [7:0] LEAD2_MASK = 8'hE0;
    localparam logic [7:0] LEAD2_CODE = 8'hC0;
    localparam logic [7:0] LEAD3_MASK = 8'hF0;
    localparam logic [7:0] LEAD3_CODE = 8'hE0;

    localparam logic [1:0] HELD_NONE = 2'd0;
    localparam logic [1:0] HELD_ONE  = 2'd1;
    localparam logic [1:0] HELD_TWO  = 2'd2;

    typedef struct packed {
        logic [7:0] text_byte;
        logic       string_last;
    } item_t;

    typedef struct packed {
        logic [1:0] count;
        logic [7:0] first;
        logic [7:0] second;
    } result_t;

    typedef struct packed {
        logic       hit;
        logic [7:0] value;
    } mapped_t;

    function automatic logic is_lead2(input logic [7:0] b);
        return (b & LEAD2_MASK) == LEAD2_CODE;
    endfunction

    function automatic logic is_lead3(input logic [7:0] b);
        return (b & LEAD3_MASK) == LEAD3_CODE;
    endfunction

    // 33..126, 161..172, 174..255 pass; 256..288 -> 0..32, 289..322 -> 127..160,
    // 323 -> 173; anything else is dropped.
    function automatic mapped_t inv_map(input logic [15:0] cp);
        mapped_t m;
        m.hit   = 1'b0;
        m.value = cp[7:0];
        if (cp inside {[16'd33:16'd126], [16'd161:16'd172], [16'd174:16'd255],
                       [16'd256:16'd288]}) begin
            m.hit = 1'b1;
        end else if (cp inside {[16'd289:16'd322]}) begin
            m.hit   = 1'b1;
            m.value = cp[7:0] + 8'd94;
        end else if (cp == 16'd323) begin
            m.hit   = 1'b1;
            m.value = 8'd173;
        end
        return m;
    endfunction

endpackage

// ----- rtl/utf8_to_byte_level_bytes.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8_to_byte_level_bytes
// UTF-8 token text to original bytes through the inverse byte-level map.
// ----------------------------------------------------------------------------
//  channel | dir | tdata          | tlast
//  s_      | in  | [7:0] text_byte | string_last
//  m_      | out | [7:0] out_byte  | run_end
//
// One input beat per cycle while the result register can take it: input
// register, decode logic, result register. An input gives 0, 1 or 2 result
// beats; a two-result input holds the input side while the register drains.
// Reset (aresetn low, synchronous) clears pending bytes and both registers.
// Stalls on m_tready back up through the result register to s_tready.
// ----------------------------------------------------------------------------
module utf8_to_byte_level_bytes (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] text_byte
    input  logic       s_tlast,
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] out_byte
    output logic       m_tlast
);
    import u2b_pkg::*;

    item_t   s_item;
    item_t   item;
    result_t res;
    logic    valid;
    logic    free;
    logic    advance;

    assign s_item.text_byte   = s_tdata;
    assign s_item.string_last = s_tlast;
    assign advance            = valid && free;

    u2b_inreg u_inreg (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_item   (s_item),
        .advance  (advance),
        .valid    (valid),
        .item     (item)
    );

    u2b_decode u_decode (
        .aclk    (aclk),
        .aresetn (aresetn),
        .advance (advance),
        .item    (item),
        .res     (res)
    );

    u2b_outbuf u_outbuf (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (advance),
        .res      (res),
        .free     (free),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule

// ----- rtl/u2b_inreg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u2b_inreg
// Input register: holds one accepted beat until the decode stage takes it.
// ----------------------------------------------------------------------------
module u2b_inreg (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_tvalid,
    output logic           s_tready,
    input  u2b_pkg::item_t s_item,
    input  logic           advance,
    output logic           valid,
    output u2b_pkg::item_t item
);
    import u2b_pkg::*;

    logic  valid_reg;
    item_t item_reg;

    assign s_tready = !valid_reg || advance;
    assign valid    = valid_reg;
    assign item     = item_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_tready) begin
            valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            item_reg <= s_item;
        end
    end

endmodule

// ----- rtl/u2b_decode.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u2b_decode
// UTF-8 sequence assembly and inverse byte-level map; owns the pending bytes.
// ----------------------------------------------------------------------------
module u2b_decode (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             advance,
    input  u2b_pkg::item_t   item,
    output u2b_pkg::result_t res
);
    import u2b_pkg::*;

    logic [7:0] lead_held_reg, lead_held_next;
    logic [7:0] second_held_reg, second_held_next;
    logic [1:0] held_count_reg, held_count_next;

    logic        want_a, want_b;
    logic [15:0] cp_a, cp_b;
    mapped_t     map_a, map_b;
    logic [7:0]  b;
    logic        last;

    assign b    = item.text_byte;
    assign last = item.string_last;

    always_comb begin
        want_a           = 1'b0;
        want_b           = 1'b0;
        cp_a             = {8'd0, QMARK};
        cp_b             = {8'd0, QMARK};
        lead_held_next   = lead_held_reg;
        second_held_next = second_held_reg;
        held_count_next  = HELD_NONE;

        if (held_count_reg == HELD_ONE && is_lead2(lead_held_reg)) begin
            want_a = 1'b1;
            cp_a   = {5'd0, lead_held_reg[4:0], b[5:0]};
        end else if (held_count_reg == HELD_ONE && is_lead3(lead_held_reg)) begin
            if (last) begin
                // lead cut short: '?' for it, then this byte alone
                want_a = 1'b1;
                want_b = 1'b1;
                cp_b   = b[7] ? {8'd0, QMARK} : {8'd0, b};
            end else begin
                second_held_next = b;
                held_count_next  = HELD_TWO;
            end
        end else if (held_count_reg == HELD_TWO) begin
            want_a = 1'b1;
            cp_a   = {lead_held_reg[3:0], second_held_reg[5:0], b[5:0]};
        end else begin
            if (!b[7]) begin
                want_a = 1'b1;
                cp_a   = {8'd0, b};
            end else if ((is_lead2(b) || is_lead3(b)) && !last) begin
                lead_held_next  = b;
                held_count_next = HELD_ONE;
            end else begin
                want_a = 1'b1;
            end
        end

        map_a = want_a ? inv_map(cp_a) : '0;
        map_b = want_b ? inv_map(cp_b) : '0;

        res.count  = {1'b0, map_a.hit} + {1'b0, map_b.hit};
        res.first  = map_a.hit ? map_a.value : map_b.value;
        res.second = map_b.value;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lead_held_reg   <= 8'd0;
            second_held_reg <= 8'd0;
            held_count_reg  <= HELD_NONE;
        end else if (advance) begin
            lead_held_reg   <= lead_held_next;
            second_held_reg <= second_held_next;
            held_count_reg  <= held_count_next;
        end
    end

endmodule

// ----- rtl/u2b_outbuf.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u2b_outbuf
// Result register: holds up to two bytes from one input and shifts them out.
// ----------------------------------------------------------------------------
module u2b_outbuf (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             load,
    input  u2b_pkg::result_t res,
    output logic             free,
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [7:0]       m_tdata,
    output logic             m_tlast
);
    import u2b_pkg::*;

    logic [1:0] count_reg;
    logic [7:0] first_reg;
    logic [7:0] second_reg;

    assign m_tvalid = count_reg != 2'd0;
    assign m_tlast  = count_reg == 2'd1;
    assign m_tdata  = first_reg;
    // slot is free when empty or once its final beat goes out this cycle
    assign free     = (count_reg == 2'd0) || (count_reg == 2'd1 && m_tready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= 2'd0;
        end else if (load) begin
            count_reg <= res.count;
        end else if (m_tvalid && m_tready) begin
            count_reg <= count_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            first_reg  <= res.first;
            second_reg <= res.second;
        end else if (m_tvalid && m_tready) begin
            first_reg  <= second_reg;
        end
    end

endmodule

// ----- rtl/u2b_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u2b_checker
// Port-level checks for the byte-level decoder, bound to the top level.
// ----------------------------------------------------------------------------
`include "utf8_to_byte_level_bytes_defines.svh"

module u2b_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_tready,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata,
    input logic       m_tlast
);
    import u2b_pkg::*;

    logic m_stall;
    assign m_stall = m_tvalid && !m_tready;

    // a stalled result beat stays up with the same data
    `U2B_ASSERT_NEXT(a_hold_valid, m_stall, m_tvalid)
    `U2B_ASSERT_NEXT(a_hold_data, m_stall, $stable(m_tdata) && $stable(m_tlast))
    // only a cut-short lead yields two beats, and its first beat is always '?'
    `U2B_ASSERT_NOW(a_pair_qmark, m_tvalid && !m_tlast, m_tdata == QMARK)
    // an empty result register never blocks the input side
    `U2B_ASSERT_NOW(a_ready_when_empty, !m_tvalid, s_tready)
    // nothing comes out in the cycle after reset
    `U2B_ASSERT_ALWAYS(a_reset_empty, !aresetn, !m_tvalid)

endmodule

bind utf8_to_byte_level_bytes u2b_checker u_u2b_checker (.*);

// ----- sim/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the UTF-8 to byte-level byte decoder. A local
// decoder model tracks the pending lead/second bytes, predicts the bytes each
// accepted input beat should produce, and the result monitor compares every
// output beat against them. Directed strings come first, then random token
// strings under varying source/sink throttling, then a long sink hold-off.
// ----------------------------------------------------------------------------
module tb_top;
    import u2b_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 12;
    localparam int HOLD_OFF       = 300;

    typedef struct {
        logic [7:0] value;
        logic       run_end;
    } out_beat_t;

    logic       aclk     = 1'b0;
    logic       aresetn  = 1'b0;
    logic       s_tvalid = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata  = 8'd0;
    logic       s_tlast  = 1'b0;
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;
    logic       m_tlast;

    // decoder model state
    logic [7:0] lead_q   = 8'd0;
    logic [7:0] second_q = 8'd0;
    logic [1:0] held_q   = HELD_NONE;

    out_beat_t  decoded_q [$];
    int         err_count    = 0;
    int         src_idle_pct = 0;
    int         snk_idle_pct = 0;
    int         stall_req    = 0;
    int         stall_left   = 0;
    int         idle_cycles  = 0;

    utf8_to_byte_level_bytes dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    always #6 aclk = ~aclk;

    // Code point back to the original byte; 0 when the code point is dropped.
    function automatic logic unmap_codepoint(input logic [15:0] cp, output logic [7:0] b);
        b = cp[7:0];
        if ((cp >= 16'd33 && cp <= 16'd126) || (cp >= 16'd161 && cp <= 16'd172) ||
            (cp >= 16'd174 && cp <= 16'd255)) begin
            return 1'b1;
        end
        if (cp >= 16'd256 && cp <= 16'd288) begin
            b = 8'(cp - 16'd256);
            return 1'b1;
        end
        if (cp >= 16'd289 && cp <= 16'd322) begin
            b = 8'(cp - 16'd289 + 16'd127);
            return 1'b1;
        end
        if (cp == 16'd323) begin
            b = 8'd173;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic void decode_text_byte(input logic [7:0] b, input logic last);
        logic [15:0] cps [0:1];
        logic [7:0]  mapped [0:1];
        logic [7:0]  m;
        out_beat_t   beat;
        int          n_cp;
        int          n_out;
        n_cp  = 0;
        n_out = 0;
        if (held_q == HELD_ONE && (lead_q & LEAD2_MASK) == LEAD2_CODE) begin
            cps[0] = {5'b0, lead_q[4:0], b[5:0]};
            n_cp   = 1;
            held_q = HELD_NONE;
        end else if (held_q == HELD_ONE && (lead_q & LEAD3_MASK) == LEAD3_CODE) begin
            if (last) begin
                // 3-byte lead cut after one byte: '?' for the lead, byte stands alone
                cps[0] = {8'd0, QMARK};
                cps[1] = b[7] ? {8'd0, QMARK} : {8'd0, b};
                n_cp   = 2;
                held_q = HELD_NONE;
            end else begin
                second_q = b;
                held_q   = HELD_TWO;
            end
        end else if (held_q == HELD_TWO) begin
            cps[0] = {lead_q[3:0], second_q[5:0], b[5:0]};
            n_cp   = 1;
            held_q = HELD_NONE;
        end else begin
            held_q = HELD_NONE;
            if (!b[7]) begin
                cps[0] = {8'd0, b};
                n_cp   = 1;
            end else if (((b & LEAD2_MASK) == LEAD2_CODE ||
                          (b & LEAD3_MASK) == LEAD3_CODE) && !last) begin
                lead_q = b;
                held_q = HELD_ONE;
            end else begin
                cps[0] = {8'd0, QMARK};
                n_cp   = 1;
            end
        end
        for (int i = 0; i < n_cp; i++) begin
            if (unmap_codepoint(cps[i], m)) begin
                mapped[n_out] = m;
                n_out++;
            end
        end
        for (int i = 0; i < n_out; i++) begin
            beat.value   = mapped[i];
            beat.run_end = (i == n_out - 1);
            decoded_q.insert(decoded_q.size(), beat);
        end
    endfunction

    // Entered and left at a falling edge.
    task automatic send_byte(input logic [7:0] b, input logic last);
        while ($urandom_range(99) < src_idle_pct) begin
            s_tvalid = 1'b0;
            @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tdata  = b;
        s_tlast  = last;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        decode_text_byte(b, last);
        @(negedge aclk);
    endtask

    task automatic wait_drain();
        s_tvalid = 1'b0;
        while (decoded_q.size() != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    task automatic test_directed();
        src_idle_pct = 7;
        snk_idle_pct = 56;
        send_byte(8'h00, 1'b1);   // control char, dropped
        send_byte(8'h7F, 1'b0);   // DEL, dropped
        send_byte(8'h21, 1'b0);
        send_byte(8'hC4, 1'b0);   // U+0100 -> 0x00, last on completing byte
        send_byte(8'h80, 1'b1);
        send_byte(8'hC5, 1'b0);   // U+0143 -> 0xAD
        send_byte(8'h83, 1'b0);
        send_byte(8'hC2, 1'b0);   // U+00AD itself is not in the map
        send_byte(8'hAD, 1'b0);
        send_byte(8'hC3, 1'b0);   // continuation top bits ignored -> 0xFF
        send_byte(8'hFF, 1'b0);
        send_byte(8'hE0, 1'b0);   // overlong 3-byte U+0100
        send_byte(8'h84, 1'b0);
        send_byte(8'h80, 1'b1);
        send_byte(8'hEF, 1'b0);   // U+FFFF, dropped
        send_byte(8'hBF, 1'b0);
        send_byte(8'hBF, 1'b0);
        send_byte(8'hE5, 1'b0);   // 3-byte lead cut short by ASCII
        send_byte(8'h41, 1'b1);
        send_byte(8'h80, 1'b0);   // stray continuation
        send_byte(8'hFF, 1'b1);   // stray 4-byte-class byte
        send_byte(8'hC3, 1'b1);   // lead at string end
        send_byte(8'hE1, 1'b0);   // 3-byte lead cut short by non-ASCII
        send_byte(8'hC0, 1'b1);
        wait_drain();
    endtask

    task automatic test_random_strings(input int n_items, input int src_pct, input int snk_pct);
        logic [7:0]  text [$];
        logic [15:0] cp;
        logic [1:0]  hi;
        int          sent;
        int          n_cp;
        int          keep;
        src_idle_pct = src_pct;
        snk_idle_pct = snk_pct;
        sent = 0;
        while (sent < n_items) begin
            text.delete();
            n_cp = $urandom_range(1, 6);
            repeat (n_cp) begin
                // continuation prefix is not checked by the block
                hi = ($urandom_range(7) == 0) ? 2'($urandom) : 2'b10;
                case ($urandom_range(9))
                    0, 1, 2, 3: begin
                        text.insert(text.size(), 8'($urandom_range(127)));
                    end
                    4, 5, 6, 7: begin
                        cp = ($urandom_range(3) == 0) ? 16'($urandom_range(128, 2047))
                                                      : 16'($urandom_range(128, 323));
                        text.insert(text.size(), {3'b110, cp[10:6]});
                        text.insert(text.size(), {hi, cp[5:0]});
                    end
                    8: begin
                        cp = ($urandom_range(1) == 0) ? 16'($urandom_range(256, 323))
                                                      : 16'($urandom);
                        text.insert(text.size(), {4'b1110, cp[15:12]});
                        text.insert(text.size(), {hi, cp[11:6]});
                        text.insert(text.size(), {2'b10, cp[5:0]});
                    end
                    default: begin
                        text.insert(text.size(), 8'($urandom));
                    end
                endcase
            end
            // now and then cut the string, leaving a sequence open at the end
            if ($urandom_range(9) == 0 && text.size() > 1) begin
                keep = $urandom_range(1, text.size() - 1);
                while (text.size() > keep) void'(text.pop_back());
            end
            foreach (text[i]) send_byte(text[i], i == text.size() - 1);
            sent += text.size();
        end
        wait_drain();
    endtask

    // Sink holds off while the source keeps pushing; input side must stall.
    task automatic test_backpressure();
        src_idle_pct = 0;
        snk_idle_pct = 0;
        @(posedge aclk);
        stall_req = HOLD_OFF;
        @(negedge aclk);
        repeat (60) begin
            if ($urandom_range(1) == 0) begin
                send_byte(8'($urandom_range(33, 126)), 1'($urandom_range(3) == 0));
            end else begin
                send_byte({3'b110, 5'($urandom_range(4, 5))}, 1'b0);
                send_byte(8'($urandom_range(128, 191)), 1'b0);
            end
        end
        wait_drain();
    endtask

    always @(negedge aclk) begin
        if (stall_req > 0) begin
            stall_left = stall_req;
            stall_req  = 0;
        end
        if (stall_left > 0) begin
            m_tready = 1'b0;
            stall_left--;
        end else begin
            m_tready = ($urandom_range(99) >= snk_idle_pct);
        end
    end

    always @(posedge aclk) begin
        out_beat_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (decoded_q.size() == 0) begin
                $display("%0t: unexpected beat: expected none, got out_byte=0x%02h run_end=%0b",
                         $time, m_tdata, m_tlast);
                err_count++;
            end else begin
                want = decoded_q.pop_front();
                if (m_tdata !== want.value) begin
                    $display("%0t: out_byte mismatch: expected 0x%02h, got 0x%02h",
                             $time, want.value, m_tdata);
                    err_count++;
                end
                if (m_tlast !== want.run_end) begin
                    $display("%0t: run_end mismatch: expected %0b, got %0b",
                             $time, want.run_end, m_tlast);
                    err_count++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: watchdog, no beat accepted for %0d cycles", $time, idle_cycles);
            $display("utf8_to_byte_level_bytes verification failed");
            $finish;
        end
    end

    initial begin
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
        test_directed();
        test_random_strings(540, 7, 56);
        test_random_strings(540, 56, 7);
        test_random_strings(540, 0, 0);
        test_backpressure();
        if (err_count == 0) begin
            $display("utf8_to_byte_level_bytes verification clean");
        end else begin
            $display("utf8_to_byte_level_bytes verification failed");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
+incdir+rtl
rtl/u2b_pkg.sv
rtl/u2b_inreg.sv
rtl/u2b_decode.sv
rtl/u2b_outbuf.sv
rtl/utf8_to_byte_level_bytes.sv
rtl/u2b_checker.sv
sim/tb_top.sv
